// ===== src/epf_pkg.sv =====
// Shared types and constants for the escaped packet framer.
// Holds register indexes, register reset values and the output sequencer states.
`timescale 1ns / 1ps
`default_nettype none

package epf_pkg;

  localparam int FLAG_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 15;
  localparam int SUM_W   = 16;
  localparam int CIDX_W  = 3;

  localparam logic [CIDX_W-1:0] REG_START_FLAG  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_END_FLAG    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ESCAPE_FLAG = 3'd2;
  localparam logic [CIDX_W-1:0] REG_START_SUBST = 3'd3;
  localparam logic [CIDX_W-1:0] REG_END_SUBST   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_ESC_SUBST   = 3'd5;

  localparam logic [FLAG_W-1:0] RST_START_FLAG  = 7'd1;
  localparam logic [FLAG_W-1:0] RST_END_FLAG    = 7'd2;
  localparam logic [FLAG_W-1:0] RST_ESCAPE_FLAG = 7'd3;
  localparam logic [BYTE_W-1:0] RST_START_SUBST = 8'd1;
  localparam logic [BYTE_W-1:0] RST_END_SUBST   = 8'd2;
  localparam logic [BYTE_W-1:0] RST_ESC_SUBST   = 8'd3;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  localparam logic [SUM_W-1:0] LEN_OVERHEAD = 16'd3;

  typedef enum logic [8:0] {
    SEG_IDLE   = 9'b000000001,
    SEG_START  = 9'b000000010,
    SEG_LEN_LO = 9'b000000100,
    SEG_LEN_HI = 9'b000001000,
    SEG_CMD    = 9'b000010000,
    SEG_DATA   = 9'b000100000,
    SEG_SUM_LO = 9'b001000000,
    SEG_SUM_HI = 9'b010000000,
    SEG_END    = 9'b100000000
  } seg_t;

endpackage

`default_nettype wire

// ===== src/escaped_packet_framer.sv =====
// Top level of the escaped packet framer: frame state, checksum and byte sequencer.
// Depends on epf_pkg for register indexes, reset values and sequencer states.
//
//   channel | ports                                               | handshake
//   --------+-----------------------------------------------------+-----------
//   in      | in_req_type in_command in_payload_length in_data_byte | valid/ready
//   out     | out_byte out_run_last out_frame_end                   | valid/ready
//   cfg     | cfg_we cfg_index cfg_wdata                            | write enable
//
// One output beat per cycle while out_ready holds; an item yields 1 to 11 bytes,
// the sequencer stepping one output byte per accepted beat. A payload beat while idle
// yields nothing. The next item is taken in the cycle its
// predecessor's last byte is taken, so the output stream has no gaps.
// Reset is synchronous, active low; it restores register defaults and idles the framer.
// A stall on out holds the current byte; in_ready falls until the burst drains.
`timescale 1ns / 1ps
`default_nettype none

module escaped_packet_framer
  import epf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  input  wire logic [BYTE_W-1:0] in_command,
  input  wire logic [LEN_W-1:0]  in_payload_length,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_run_last,
  output logic                   out_frame_end,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_wdata
);

  logic [FLAG_W-1:0] start_flag_r, end_flag_r, escape_flag_r;
  logic [BYTE_W-1:0] start_subst_r, end_subst_r, esc_subst_r;

  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              in_frame_r, in_frame_nxt;

  seg_t              seg_r, seg_nxt, seg_follow;
  logic              sub_r, sub_nxt;
  logic [SUM_W-1:0]  job_len_r, job_len_nxt;
  logic [BYTE_W-1:0] job_cmd_r, job_cmd_nxt;
  logic [BYTE_W-1:0] job_data_r, job_data_nxt;
  logic              job_tail_r, job_tail_nxt;

  logic              in_acc, out_acc, emits;
  logic [SUM_W-1:0]  len_word, cmd_ext;
  logic [LEN_W-1:0]  left_dec;
  logic [BYTE_W-1:0] cur_val, subst;
  logic              escapable, hit_start, hit_end, hit_esc, esc, seg_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_flag_r  <= RST_START_FLAG;
      end_flag_r    <= RST_END_FLAG;
      escape_flag_r <= RST_ESCAPE_FLAG;
      start_subst_r <= RST_START_SUBST;
      end_subst_r   <= RST_END_SUBST;
      esc_subst_r   <= RST_ESC_SUBST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_FLAG:  start_flag_r  <= cfg_wdata[FLAG_W-1:0];
        REG_END_FLAG:    end_flag_r    <= cfg_wdata[FLAG_W-1:0];
        REG_ESCAPE_FLAG: escape_flag_r <= cfg_wdata[FLAG_W-1:0];
        REG_START_SUBST: start_subst_r <= cfg_wdata;
        REG_END_SUBST:   end_subst_r   <= cfg_wdata;
        REG_ESC_SUBST:   esc_subst_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Byte currently presented and its escaping
  always_comb begin
    unique case (seg_r)
      SEG_LEN_LO: cur_val = job_len_r[7:0];
      SEG_LEN_HI: cur_val = job_len_r[15:8];
      SEG_DATA:   cur_val = job_data_r;
      SEG_SUM_LO: cur_val = sum_r[7:0];
      SEG_SUM_HI: cur_val = sum_r[15:8];
      default:    cur_val = '0;
    endcase
  end

  assign escapable = (seg_r == SEG_LEN_LO) || (seg_r == SEG_LEN_HI) || (seg_r == SEG_DATA) ||
                     (seg_r == SEG_SUM_LO) || (seg_r == SEG_SUM_HI);
  assign hit_start = (cur_val == {1'b0, start_flag_r});
  assign hit_end   = (cur_val == {1'b0, end_flag_r});
  assign hit_esc   = (cur_val == {1'b0, escape_flag_r});
  assign esc       = escapable && (hit_start || hit_end || hit_esc);

  always_comb begin
    priority if (hit_start) subst = start_subst_r;
    else if (hit_end)       subst = end_subst_r;
    else                    subst = esc_subst_r;
  end

  always_comb begin
    unique case (seg_r)
      SEG_START: out_byte = {1'b0, start_flag_r};
      SEG_END:   out_byte = {1'b0, end_flag_r};
      SEG_CMD:   out_byte = job_cmd_r;
      default:   out_byte = esc ? (sub_r ? subst : {1'b0, escape_flag_r}) : cur_val;
    endcase
  end

  always_comb begin
    unique case (seg_r)
      SEG_START:  seg_follow = SEG_LEN_LO;
      SEG_LEN_LO: seg_follow = SEG_LEN_HI;
      SEG_LEN_HI: seg_follow = SEG_CMD;
      SEG_CMD:    seg_follow = job_tail_r ? SEG_SUM_LO : SEG_IDLE;
      SEG_DATA:   seg_follow = job_tail_r ? SEG_SUM_LO : SEG_IDLE;
      SEG_SUM_LO: seg_follow = SEG_SUM_HI;
      SEG_SUM_HI: seg_follow = SEG_END;
      default:    seg_follow = SEG_IDLE;
    endcase
  end

  assign seg_done      = !esc || sub_r;
  assign out_valid     = (seg_r != SEG_IDLE);
  assign out_run_last  = seg_done && (seg_follow == SEG_IDLE);
  assign out_frame_end = (seg_r == SEG_END);
  assign out_acc       = out_valid && out_ready;

  assign in_ready = !out_valid || (out_ready && out_run_last);
  assign in_acc   = in_valid && in_ready;

  // Frame state update on an accepted beat
  assign len_word = {1'b0, in_payload_length} + LEN_OVERHEAD;
  assign cmd_ext  = {{(SUM_W-BYTE_W){in_command[BYTE_W-1]}}, in_command};
  assign left_dec = bytes_left_r - LEN_W'(1);

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    sum_nxt        = sum_r;
    in_frame_nxt   = in_frame_r;
    job_len_nxt    = job_len_r;
    job_cmd_nxt    = job_cmd_r;
    job_data_nxt   = job_data_r;
    job_tail_nxt   = job_tail_r;
    emits          = 1'b0;
    if (in_acc) begin
      if (in_req_type == REQ_START) begin
        emits          = 1'b1;
        sum_nxt        = len_word + cmd_ext;
        bytes_left_nxt = in_payload_length;
        in_frame_nxt   = (in_payload_length != '0);
        job_len_nxt    = len_word;
        job_cmd_nxt    = in_command;
        job_tail_nxt   = (in_payload_length == '0);
      end else if (in_frame_r) begin
        emits          = 1'b1;
        sum_nxt        = sum_r + {{(SUM_W-BYTE_W){1'b0}}, in_data_byte};
        bytes_left_nxt = left_dec;
        in_frame_nxt   = (left_dec != '0);
        job_data_nxt   = in_data_byte;
        job_tail_nxt   = (left_dec == '0);
      end
    end
  end

  // Sequencer: load on a new burst, else advance one byte per beat
  always_comb begin
    seg_nxt = seg_r;
    sub_nxt = sub_r;
    if (emits) begin
      seg_nxt = (in_req_type == REQ_START) ? SEG_START : SEG_DATA;
      sub_nxt = 1'b0;
    end else if (out_acc) begin
      if (seg_done) begin
        seg_nxt = seg_follow;
        sub_nxt = 1'b0;
      end else begin
        sub_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r        <= SEG_IDLE;
      sub_r        <= 1'b0;
      in_frame_r   <= 1'b0;
      bytes_left_r <= '0;
      sum_r        <= '0;
    end else begin
      seg_r        <= seg_nxt;
      sub_r        <= sub_nxt;
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_len_r  <= job_len_nxt;
    job_cmd_r  <= job_cmd_nxt;
    job_data_r <= job_data_nxt;
    job_tail_r <= job_tail_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for escaped_packet_framer: random and directed frames, checked beat by beat.
// Holds a scoreboard class that predicts the escaped byte stream; depends on epf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import epf_pkg::*;

  localparam logic [CIDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CIDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              fend;
  } beat_t;

  class framer_scoreboard;
    logic [FLAG_W-1:0] start_flag, end_flag, escape_flag;
    logic [BYTE_W-1:0] start_subst, end_subst, escape_subst;
    logic [LEN_W-1:0]  bytes_left;
    logic [SUM_W-1:0]  frame_sum;
    bit                in_frame;
    beat_t             expected_stream[$];
    int                errors;

    function new();
      start_flag   = RST_START_FLAG;
      end_flag     = RST_END_FLAG;
      escape_flag  = RST_ESCAPE_FLAG;
      start_subst  = RST_START_SUBST;
      end_subst    = RST_END_SUBST;
      escape_subst = RST_ESC_SUBST;
      bytes_left   = '0;
      frame_sum    = '0;
      in_frame     = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [BYTE_W-1:0] value);
      case (idx)
        REG_START_FLAG:  start_flag   = value[FLAG_W-1:0];
        REG_END_FLAG:    end_flag     = value[FLAG_W-1:0];
        REG_ESCAPE_FLAG: escape_flag  = value[FLAG_W-1:0];
        REG_START_SUBST: start_subst  = value;
        REG_END_SUBST:   end_subst    = value;
        REG_ESC_SUBST:   escape_subst = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_stream.size();
    endfunction

    function void push_raw(logic [BYTE_W-1:0] b, logic fend);
      beat_t e;
      e.data = b;
      e.last = 1'b0;
      e.fend = fend;
      expected_stream.push_back(e);
    endfunction

    function void push_escaped(logic [BYTE_W-1:0] b);
      if (b == {1'b0, start_flag}) begin
        push_raw({1'b0, escape_flag}, 1'b0);
        push_raw(start_subst, 1'b0);
      end else if (b == {1'b0, end_flag}) begin
        push_raw({1'b0, escape_flag}, 1'b0);
        push_raw(end_subst, 1'b0);
      end else if (b == {1'b0, escape_flag}) begin
        push_raw({1'b0, escape_flag}, 1'b0);
        push_raw(escape_subst, 1'b0);
      end else begin
        push_raw(b, 1'b0);
      end
    endfunction

    function void push_tail();
      push_escaped(frame_sum[7:0]);
      push_escaped(frame_sum[15:8]);
      push_raw({1'b0, end_flag}, 1'b1);
      in_frame   = 1'b0;
      bytes_left = '0;
    endfunction

    function void note_item(logic req, logic [BYTE_W-1:0] cmd, logic [LEN_W-1:0] plen,
                            logic [BYTE_W-1:0] data);
      int first;
      logic [SUM_W-1:0] len_word;
      first = expected_stream.size();
      if (req == REQ_START) begin
        len_word   = {1'b0, plen} + LEN_OVERHEAD;
        frame_sum  = len_word + {{8{cmd[7]}}, cmd};
        bytes_left = plen;
        in_frame   = 1'b1;
        push_raw({1'b0, start_flag}, 1'b0);
        push_escaped(len_word[7:0]);
        push_escaped(len_word[15:8]);
        push_raw(cmd, 1'b0);
        if (bytes_left == 0) push_tail();
      end else if (in_frame) begin
        frame_sum = frame_sum + {8'h00, data};
        push_escaped(data);
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) push_tail();
      end
      if (expected_stream.size() > first)
        expected_stream[expected_stream.size() - 1].last = 1'b1;
    endfunction

    function void check_beat(logic [BYTE_W-1:0] b, logic last, logic fend);
      beat_t e;
      if (expected_stream.size() == 0) begin
        $display("%0t: unexpected beat: out_byte %02h run_last %b frame_end %b",
                 $time, b, last, fend);
        errors++;
        return;
      end
      e = expected_stream.pop_front();
      if (b !== e.data) begin
        $display("%0t: out_byte expected %02h got %02h", $time, e.data, b);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: out_run_last expected %b got %b", $time, e.last, last);
        errors++;
      end
      if (fend !== e.fend) begin
        $display("%0t: out_frame_end expected %b got %b", $time, e.fend, fend);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_req_type = REQ_START;
  logic [BYTE_W-1:0] in_command = '0;
  logic [LEN_W-1:0]  in_payload_length = '0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_run_last;
  logic              out_frame_end;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = REG_START_FLAG;
  logic [BYTE_W-1:0] cfg_wdata = '0;

  framer_scoreboard sb;
  int idle_pct = 30;
  int stall_cycles = 0;

  escaped_packet_framer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_command        (in_command),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_frame_end     (out_frame_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_item(in_req_type, in_command, in_payload_length, in_data_byte);
      if (out_valid && out_ready)
        sb.check_beat(out_byte, out_run_last, out_frame_end);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // hold off the result side in random bursts
  initial begin
    @(posedge clk);
    forever begin
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_item(logic req, logic [BYTE_W-1:0] cmd, logic [LEN_W-1:0] plen,
                           logic [BYTE_W-1:0] data);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_command        <= cmd;
    in_payload_length <= plen;
    in_data_byte      <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_start(logic [BYTE_W-1:0] cmd, logic [LEN_W-1:0] plen);
    send_item(REQ_START, cmd, plen, BYTE_W'($urandom));
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] data);
    send_item(REQ_PAYLOAD, BYTE_W'($urandom), LEN_W'($urandom), data);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [BYTE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic program_regs(logic [FLAG_W-1:0] sf, logic [FLAG_W-1:0] ef,
                              logic [FLAG_W-1:0] xf, logic [BYTE_W-1:0] ss,
                              logic [BYTE_W-1:0] es, logic [BYTE_W-1:0] xs);
    write_cfg(REG_START_FLAG, {1'($urandom_range(0, 1)), sf});
    write_cfg(REG_END_FLAG, {1'($urandom_range(0, 1)), ef});
    write_cfg(REG_ESCAPE_FLAG, {1'($urandom_range(0, 1)), xf});
    write_cfg(REG_START_SUBST, ss);
    write_cfg(REG_END_SUBST, es);
    write_cfg(REG_ESC_SUBST, xs);
    write_cfg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, BYTE_W'($urandom));
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic run_frames(int n_items);
    int done_items;
    int r;
    int sent;
    logic [LEN_W-1:0]  plen;
    logic [BYTE_W-1:0] d;
    done_items = 0;
    while (done_items < n_items) begin
      if ($urandom_range(0, 99) < 6) begin
        send_byte(BYTE_W'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10)      plen = '0;
        else if (r < 80) plen = LEN_W'($urandom_range(1, 8));
        else if (r < 95) plen = LEN_W'($urandom_range(9, 40));
        else             plen = LEN_W'($urandom_range(41, 32767));
        sent = plen;
        // drop the frame early now and then, always past 40 bytes; the next start abandons it
        if (plen != 0 && (plen > 40 || $urandom_range(0, 99) < 8))
          sent = $urandom_range(0, (plen > 10) ? 10 : plen - 1);
        send_start(BYTE_W'($urandom), plen);
        done_items++;
        repeat (sent) begin
          case ($urandom_range(0, 9))
            0: d = {1'b0, sb.start_flag};
            1: d = {1'b0, sb.end_flag};
            2: d = {1'b0, sb.escape_flag};
            3: d = {1'b1, sb.escape_flag};
            default: d = BYTE_W'($urandom);
          endcase
          send_byte(d);
          done_items++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty payloads with checksum bytes hitting the flags
    send_start(8'h00, 15'd0);
    send_start(8'hFE, 15'd0);
    send_start(8'hFF, 15'd0);
    send_byte(8'hAA);
    send_start(8'h80, 15'd4);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'hFF);
    // abandoned frames, length word with both bytes escaped, largest lengths
    send_start(8'h7F, 15'd254);
    send_byte(8'h00);
    send_byte(8'h80);
    send_start(8'h55, 15'd32767);
    send_byte(8'h7F);
    send_start(8'hAA, 15'd32764);
    send_start(8'h01, 15'd1);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained();

    run_frames(80);
    wait_drained();

    idle_pct = 50;
    program_regs(FLAG_W'($urandom), FLAG_W'($urandom), FLAG_W'($urandom),
                 BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    run_frames(70);
    wait_drained();

    idle_pct = 0;
    program_regs(7'h00, 7'h7F, 7'h40, 8'h00, 8'hFF, 8'h80);
    run_frames(60);
    wait_drained();

    // all flags equal: the start test always wins
    idle_pct = 30;
    program_regs(7'h7E, 7'h7E, 7'h7E,
                 BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    run_frames(50);
    wait_drained();

    idle_pct = 0;
    program_regs(7'h7F, 7'h00, 7'h01, 8'hFF, 8'h00, 8'h7F);
    run_frames(60);
    wait_drained();

    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
